// ===== hw/rtl/periodic_slot_event_scheduler_defines.svh =====
// Assertion macros for the periodic slot event scheduler checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PERIODIC_SLOT_EVENT_SCHEDULER_DEFINES_SVH
`define PERIODIC_SLOT_EVENT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define PSES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("pses: assertion failed");

// Next-cycle implication, gated by reset.
`define PSES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("pses: assertion failed");

`endif

// ===== hw/rtl/pses_pkg.sv =====
// Shared types and constants for the periodic slot event scheduler.
// No dependencies; imported by every RTL module of the block.
package pses_pkg;

	localparam int NUM_SLOTS_MAX      = 8;
	localparam int DEFAULT_SLOT_COUNT = 8;
	localparam int REG_IDX_W          = $clog2(NUM_SLOTS_MAX);
	localparam int CFG_IDX_W          = REG_IDX_W + 1;
	localparam int SETUP_W            = 49;
	localparam int PC_W               = 16;
	localparam int ACT_W              = 3;
	localparam int ACTIONS_W          = ACT_W * NUM_SLOTS_MAX;

	localparam logic [PC_W-1:0] DUR_FOREVER = 16'hFFFE;
	localparam logic [PC_W-1:0] DIST_NONE   = 16'hFFFF;

	localparam int ACT_START_BIT = 0;
	localparam int ACT_STOP_BIT  = 1;
	localparam int ACT_LOG_BIT   = 2;

	// Bit layout matches the setup register: {log_step, duration, interval, enable}
	typedef struct packed {
		logic [PC_W-1:0] log_step;
		logic [PC_W-1:0] duration;
		logic [PC_W-1:0] interval;
		logic            en;
	} setup_t;

	typedef struct packed {
		logic start;    // latch count, clear accumulators
		logic step;     // process the addressed slot
		logic publish;  // move accumulators to the output register
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

endpackage

// ===== hw/rtl/pses_ctrl.sv =====
// Controller FSM: input/output handshakes, slot sweep counter, datapath commands.
// Depends on pses_pkg.
module pses_ctrl
	import pses_pkg::*;
#(
	parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
	parameter int SLOT_IDX_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cmd_t                  cmd,
	output logic [SLOT_IDX_W-1:0] slot
);

	state_t                state_q;
	logic [SLOT_IDX_W-1:0] slot_q;
	logic                  out_valid_q;
	logic                  accept;
	logic                  last_slot;
	logic                  out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign last_slot   = (slot_q == SLOT_IDX_W'(SLOT_COUNT - 1));
	assign out_free    = !out_valid_q || out_ready;
	assign cmd.start   = accept;
	assign cmd.step    = (state_q == ST_RUN);
	assign cmd.publish = (state_q == ST_FLUSH) && out_free;
	assign slot        = slot_q;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						slot_q  <= '0;
					end
				end
				ST_RUN: begin
					if (last_slot) begin
						state_q <= ST_FLUSH;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			priority if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

endmodule

// ===== hw/rtl/pses_dp.sv =====
// Datapath: setup registers, per-slot event times, one-slot update unit,
// action/distance accumulators and the output register. Depends on pses_pkg.
module pses_dp
	import pses_pkg::*;
#(
	parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
	parameter int SLOT_IDX_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [SLOT_IDX_W-1:0] slot,
	input  logic [PC_W-1:0]       period_count,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SETUP_W-1:0]    cfg_data,
	output logic [ACTIONS_W-1:0]  slot_actions,
	output logic [PC_W-1:0]       wake_distance
);

	setup_t             setup_q [NUM_SLOTS_MAX];
	logic [PC_W-1:0]    start_q [SLOT_COUNT];
	logic [PC_W-1:0]    log_q   [SLOT_COUNT];
	logic [PC_W-1:0]    stop_q  [SLOT_COUNT];
	logic [PC_W-1:0]    pc_q;
	logic [ACTIONS_W-1:0] act_acc_q;
	logic [PC_W-1:0]    dist_acc_q;
	logic [ACTIONS_W-1:0] actions_q;
	logic [PC_W-1:0]    wake_q;

	setup_t          cur;
	logic            forever_dur;
	logic [ACT_W-1:0] act;
	logic [PC_W-1:0] start_n, log_n, stop_n;
	logic [PC_W-1:0] ds, dl, dp, dist_n;

	// One slot per cycle
	always_comb begin
		cur         = setup_q[REG_IDX_W'(slot)];
		forever_dur = (cur.duration == DUR_FOREVER);
		act         = '0;
		start_n     = start_q[slot];
		log_n       = log_q[slot];
		stop_n      = stop_q[slot];
		if (pc_q == start_q[slot]) begin
			act[ACT_START_BIT] = 1'b1;
			log_n   = pc_q + cur.log_step;
			start_n = pc_q + cur.interval;
			stop_n  = pc_q + cur.duration;
		end else begin
			act[ACT_LOG_BIT]  = (pc_q == log_q[slot]);
			act[ACT_STOP_BIT] = !forever_dur && (pc_q == stop_q[slot]);
			if (act[ACT_STOP_BIT]) begin
				stop_n = pc_q - 1'b1;
				log_n  = pc_q - 1'b1;
			end else if (act[ACT_LOG_BIT]) begin
				log_n = pc_q + cur.log_step;
			end
		end
		ds     = start_n - pc_q;
		dl     = log_n - pc_q;
		dp     = stop_n - pc_q;
		dist_n = dist_acc_q;
		if (ds < dist_n) dist_n = ds;
		if (dl < dist_n) dist_n = dl;
		if (!forever_dur && dp < dist_n) dist_n = dp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS_MAX; i++) begin
				setup_q[i] <= '0;
			end
			for (int i = 0; i < SLOT_COUNT; i++) begin
				start_q[i] <= '0;
				log_q[i]   <= '0;
				stop_q[i]  <= '0;
			end
		end else begin
			if (cfg_we && cfg_index < CFG_IDX_W'(NUM_SLOTS_MAX)) begin
				setup_q[cfg_index[REG_IDX_W-1:0]] <= setup_t'(cfg_data);
			end
			if (cmd.step && cur.en) begin
				start_q[slot] <= start_n;
				log_q[slot]   <= log_n;
				stop_q[slot]  <= stop_n;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pc_q       <= period_count;
			act_acc_q  <= '0;
			dist_acc_q <= DIST_NONE;
		end else if (cmd.step && cur.en) begin
			act_acc_q  <= act_acc_q | (ACTIONS_W'(act) << (ACT_W * int'(slot)));
			dist_acc_q <= dist_n;
		end
		if (cmd.publish) begin
			actions_q <= act_acc_q;
			wake_q    <= dist_acc_q;
		end
	end

	assign slot_actions  = actions_q;
	assign wake_distance = wake_q;

endmodule

// ===== hw/rtl/periodic_slot_event_scheduler.sv =====
// Top level of the periodic slot event scheduler: controller plus datapath.
// Depends on pses_pkg, pses_ctrl and pses_dp.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  input   | in_valid / in_ready   | period_count[15:0]
//  output  | out_valid / out_ready | slot_actions[23:0], wake_distance[15:0]
//  config  | cfg_we (no wait)      | cfg_index[3:0], cfg_data[48:0]
//
// Each input beat is accepted, then swept slot by slot through the shared update
// unit, then loaded into the output register.
// The next input beat is accepted as soon as the result is in the output
// register; a stalled output holds the sweep in its final state.
// Reset clears setup registers and all slot event times to zero at once.
// Config writes with index 8 or above are dropped.
module periodic_slot_event_scheduler
	import pses_pkg::*;
#(
	parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PC_W-1:0]      period_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ACTIONS_W-1:0] slot_actions,
	output logic [PC_W-1:0]      wake_distance,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SETUP_W-1:0]   cfg_data
);

	localparam int SlotIdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	cmd_t                cmd;
	logic [SlotIdxW-1:0] slot;

	// Sequencer: handshakes and slot sweep
	pses_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_IDX_W (SlotIdxW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.slot      (slot)
	);

	// Slot state, update unit, accumulators, result register
	pses_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_IDX_W (SlotIdxW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.slot          (slot),
		.period_count  (period_count),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.slot_actions  (slot_actions),
		.wake_distance (wake_distance)
	);

endmodule

// ===== hw/rtl/pses_checker.sv =====
// Port-level checker for the periodic slot event scheduler, bound to the top.
// Depends on pses_pkg and periodic_slot_event_scheduler_defines.svh.
`include "periodic_slot_event_scheduler_defines.svh"

module pses_checker
	import pses_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [ACTIONS_W-1:0] slot_actions,
	input logic [PC_W-1:0]      wake_distance
);

	// An accepted beat keeps the block busy for the slot sweep.
	`PSES_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// A stalled result holds.
	`PSES_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(slot_actions) && $stable(wake_distance))

	// A new result only ends a sweep.
	`PSES_ASSERT_NOW(a_result_after_sweep, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// Becoming ready again always comes with a result on the output.
	`PSES_ASSERT_NOW(a_ready_with_result, clk, arst_n, $rose(in_ready), out_valid)

endmodule

bind periodic_slot_event_scheduler pses_checker u_pses_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for periodic_slot_event_scheduler: period ticks in,
// per-slot start/stop/log actions and wake distance out, checked per beat.
// Depends on pses_pkg and the periodic_slot_event_scheduler RTL.
module tb_top;
	import pses_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 7;
	// accept, then the slot sweep, then the load of the output register
	localparam int SWEEP_CYCLES   = DEFAULT_SLOT_COUNT + 2;
	localparam int SETTLE_CYCLES  = 2 * SWEEP_CYCLES;
	localparam int TIMEOUT_CYCLES = 500_000;
	localparam int ROUND_TICKS    = 33;
	localparam int PHASE_ROUNDS   = 15;
	localparam int LONG_STALL     = 300;

	localparam logic [PC_W-1:0] DUR_ONE_SHOT = 16'hFFFF;

	// Register map: slot N setup sits at index N, anything past the last slot is dropped.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOT0_SETUP,
		REG_SLOT1_SETUP,
		REG_SLOT2_SETUP,
		REG_SLOT3_SETUP,
		REG_SLOT4_SETUP,
		REG_SLOT5_SETUP,
		REG_SLOT6_SETUP,
		REG_SLOT7_SETUP,
		REG_UNMAPPED_FIRST,
		REG_UNMAPPED_LAST = {CFG_IDX_W{1'b1}}
	} setup_reg_e;

	typedef struct packed {
		logic [ACTIONS_W-1:0] actions;
		logic [PC_W-1:0]      wake;
	} tick_forecast_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [PC_W-1:0]      period_count;
	logic                 out_valid;
	logic                 out_ready;
	logic [ACTIONS_W-1:0] slot_actions;
	logic [PC_W-1:0]      wake_distance;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SETUP_W-1:0]   cfg_data;

	// Shadow copy of the block: setup registers plus the three event-time tables.
	setup_t          shadow_setup [DEFAULT_SLOT_COUNT];
	logic [PC_W-1:0] shadow_start [DEFAULT_SLOT_COUNT];
	logic [PC_W-1:0] shadow_log   [DEFAULT_SLOT_COUNT];
	logic [PC_W-1:0] shadow_stop  [DEFAULT_SLOT_COUNT];

	// Forecasts for accepted ticks, oldest first.
	tick_forecast_t forecast_q [$];

	int error_count   = 0;
	int ticks_sent    = 0;
	int setup_writes  = 0;
	int starts_seen   = 0;
	int stops_seen    = 0;
	int logs_seen     = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_request = 0;
	int stall_left    = 0;

	periodic_slot_event_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.period_count  (period_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.slot_actions  (slot_actions),
		.wake_distance (wake_distance),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Slot scheduler forecast. Walks every enabled slot in order:
	//  - count hits the start time: START only, re-arm start/stop/log
	//  - otherwise LOG on the log time, STOP on the stop time unless the
	//    duration is forever; a STOP parks both stop and log at count - 1
	// Wake distance is the least modulo-2^16 gap to any pending time,
	// skipping the stop time of forever slots.
	// ------------------------------------------------------------------
	function automatic void reset_shadow();
		for (int k = 0; k < DEFAULT_SLOT_COUNT; k++) begin
			shadow_setup[k] = '0;
			shadow_start[k] = '0;
			shadow_log[k]   = '0;
			shadow_stop[k]  = '0;
		end
	endfunction

	function automatic void forecast_tick(input logic [PC_W-1:0] count);
		tick_forecast_t  fc;
		setup_t          s;
		logic [ACT_W-1:0] act;
		logic            forever_dur;
		logic [PC_W-1:0] gap_start, gap_log, gap_stop;

		fc.actions = '0;
		fc.wake    = DIST_NONE;
		for (int k = 0; k < DEFAULT_SLOT_COUNT; k++) begin
			s = shadow_setup[k];
			if (!s.en)
				continue;
			forever_dur = (s.duration == DUR_FOREVER);
			act = '0;
			if (count == shadow_start[k]) begin
				act[ACT_START_BIT] = 1'b1;
				shadow_log[k]   = count + s.log_step;
				shadow_start[k] = count + s.interval;
				shadow_stop[k]  = count + s.duration;
			end else begin
				if (count == shadow_log[k])
					act[ACT_LOG_BIT] = 1'b1;
				if (!forever_dur && count == shadow_stop[k]) begin
					act[ACT_STOP_BIT] = 1'b1;
					shadow_stop[k] = count - 1'b1;
				end
				// the handler answers -1 once the slot stops
				if (act[ACT_STOP_BIT])
					shadow_log[k] = count - 1'b1;
				else if (act[ACT_LOG_BIT])
					shadow_log[k] = count + s.log_step;
			end
			fc.actions[ACT_W * k +: ACT_W] = act;
			starts_seen += act[ACT_START_BIT];
			stops_seen  += act[ACT_STOP_BIT];
			logs_seen   += act[ACT_LOG_BIT];

			gap_start = shadow_start[k] - count;
			gap_log   = shadow_log[k] - count;
			gap_stop  = shadow_stop[k] - count;
			if (gap_start < fc.wake)
				fc.wake = gap_start;
			if (gap_log < fc.wake)
				fc.wake = gap_log;
			if (!forever_dur && gap_stop < fc.wake)
				fc.wake = gap_stop;
		end
		forecast_q.push_back(fc);
		ticks_sent++;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: every output beat is matched against the oldest
	// forecast. Runs for the whole test; never stops the simulation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		tick_forecast_t fc;
		if (arst_n && out_valid && out_ready) begin
			if (forecast_q.size() == 0) begin
				$error("result beat with no tick outstanding: slot_actions %06h wake_distance %04h",
					slot_actions, wake_distance);
				error_count++;
			end else begin
				fc = forecast_q.pop_front();
				if (slot_actions !== fc.actions) begin
					$error("slot_actions mismatch: expected %06h, actual %06h",
						fc.actions, slot_actions);
					error_count++;
				end
				if (wake_distance !== fc.wake) begin
					$error("wake_distance mismatch: expected %04h, actual %04h",
						fc.wake, wake_distance);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output side. Random ready at the phase's idle rate; a long stall
	// request overrides it and is counted down here, cycle by cycle.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_request > 0) begin
			stall_left    = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Shared drivers. All run from a falling edge and return on one.
	// ------------------------------------------------------------------

	// One tick beat. Valid stays high into the next call, so back-to-back
	// ticks never drop it; idle gaps lower it only ahead of the new beat.
	task automatic send_tick(input logic [PC_W-1:0] count);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		period_count = count;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		forecast_tick(count);
		@(negedge clk);
	endtask

	// Setup write; mapped indexes update the shadow registers only, never
	// the event times.
	task automatic write_setup(input logic [CFG_IDX_W-1:0] idx, input logic [SETUP_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx < REG_UNMAPPED_FIRST)
			shadow_setup[idx[REG_IDX_W-1:0]] = value;
		setup_writes++;
	endtask

	// Sender pause: hold off until every forecast is matched, then let the
	// sweep settle so setup writes land on an idle block.
	task automatic wait_for_results();
		in_valid = 1'b0;
		while (forecast_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic setup_t make_setup(input logic en, input logic [PC_W-1:0] interval,
			input logic [PC_W-1:0] duration, input logic [PC_W-1:0] log_step);
		setup_t s;
		s.en       = en;
		s.interval = interval;
		s.duration = duration;
		s.log_step = log_step;
		return s;
	endfunction

	// Mostly short intervals so events recur within a tick run; extremes mixed in.
	function automatic setup_t random_setup();
		setup_t             s;
		logic [SETUP_W-1:0] raw;
		raw = SETUP_W'({$urandom, $urandom});
		if ($urandom_range(7) == 0)
			return setup_t'(raw);
		s.en = ($urandom_range(3) != 0);
		case ($urandom_range(5))
			0:       s.interval = '0;
			1:       s.interval = '1;
			5:       s.interval = PC_W'($urandom);
			default: s.interval = PC_W'($urandom_range(1, 16));
		endcase
		case ($urandom_range(8))
			0:       s.duration = DUR_ONE_SHOT;
			1:       s.duration = DUR_FOREVER;
			2:       s.duration = '0;
			3:       s.duration = 16'h7FFF;
			4:       s.duration = 16'h8000;
			8:       s.duration = PC_W'($urandom);
			default: s.duration = PC_W'($urandom_range(1, 20));
		endcase
		case ($urandom_range(8))
			0:       s.log_step = '0;
			1:       s.log_step = 16'hFFFF;
			2:       s.log_step = 16'h7FFF;
			3:       s.log_step = 16'h8000;
			4:       s.log_step = -PC_W'($urandom_range(2, 8));
			8:       s.log_step = PC_W'($urandom);
			default: s.log_step = PC_W'($urandom_range(1, 8));
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset every slot is off: no actions, wake distance saturated.
	task automatic test_all_slots_idle();
		send_tick(16'h0000);
		send_tick(16'hFFFF);
		send_tick(16'h5A5A);
		wait_for_results();
	endtask

	// Hand-picked schedules on every slot: one-shot, forever, zero interval and
	// duration, wide interval, sign extremes of duration and log step, a
	// disabled slot, dropped writes past the map, then a count wrap and a
	// repeated count.
	task automatic test_directed_schedules();
		write_setup(REG_SLOT0_SETUP, make_setup(1'b1, 16'd4, 16'd2, 16'd1));
		write_setup(REG_SLOT1_SETUP, make_setup(1'b1, 16'd6, DUR_FOREVER, 16'd2));
		write_setup(REG_SLOT2_SETUP, make_setup(1'b1, 16'd10, DUR_ONE_SHOT, 16'hFFFF));
		write_setup(REG_SLOT3_SETUP, make_setup(1'b1, 16'd0, 16'd0, 16'd0));
		write_setup(REG_SLOT4_SETUP, make_setup(1'b0, 16'd3, 16'd1, 16'd1));
		write_setup(REG_SLOT5_SETUP, make_setup(1'b1, 16'hFFFF, 16'h7FFF, 16'h8000));
		write_setup(REG_SLOT6_SETUP, make_setup(1'b1, 16'd3, 16'h8000, 16'h7FFF));
		write_setup(REG_SLOT7_SETUP, make_setup(1'b1, 16'd5, 16'd1, 16'd1));
		// past the last slot: must leave every slot untouched
		write_setup(REG_UNMAPPED_FIRST, '1);
		write_setup(REG_UNMAPPED_LAST, '1);
		for (int i = 0; i < 14; i++)
			send_tick(PC_W'(i));
		send_tick(16'hFFFE);
		send_tick(16'hFFFF);
		send_tick(16'h0000);
		send_tick(16'h0001);
		send_tick(16'h0001);
		wait_for_results();
	endtask

	// Output held off for a long stretch while ticks keep coming: the block
	// must fill, drop in_ready and lose nothing. Then the sender waits it out.
	task automatic test_output_backpressure();
		logic [PC_W-1:0] base;
		base = shadow_start[REG_SLOT0_SETUP] - 2'd2;
		stall_request = LONG_STALL;
		for (int i = 0; i < 30; i++)
			send_tick(base + PC_W'(i));
		wait_for_results();
	endtask

	// Random setups per round, then mostly contiguous tick runs aimed just
	// ahead of some slot's pending start, with jumps and repeats as noise.
	task automatic test_random_schedules(input int tx_idle, input int rx_idle);
		int              sent;
		int              run_len;
		int              anchor;
		logic [PC_W-1:0] base;

		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		for (int r = 0; r < PHASE_ROUNDS; r++) begin
			wait_for_results();
			for (int k = 0; k < DEFAULT_SLOT_COUNT; k++)
				if ($urandom_range(1) == 0)
					write_setup(CFG_IDX_W'(REG_SLOT0_SETUP + k), random_setup());
			if ($urandom_range(9) == 0)
				write_setup(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
					SETUP_W'({$urandom, $urandom}));
			sent = 0;
			while (sent < ROUND_TICKS) begin
				case ($urandom_range(9))
					0: begin
						// noise: scattered counts
						run_len = $urandom_range(1, 4);
						for (int i = 0; i < run_len; i++)
							send_tick(PC_W'($urandom));
					end
					1: begin
						// same count twice, then a step backwards
						base = PC_W'($urandom);
						send_tick(base);
						send_tick(base);
						send_tick(base - 1'b1);
						run_len = 3;
					end
					2: begin
						run_len = $urandom_range(4, 16);
						base = PC_W'($urandom);
						for (int i = 0; i < run_len; i++)
							send_tick(base + PC_W'(i));
					end
					default: begin
						anchor  = $urandom_range(DEFAULT_SLOT_COUNT - 1);
						run_len = $urandom_range(4, 24);
						base    = shadow_start[anchor] - PC_W'($urandom_range(3));
						for (int i = 0; i < run_len; i++)
							send_tick(base + PC_W'(i));
					end
				endcase
				sent += run_len;
			end
		end
		wait_for_results();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		in_valid     = 1'b0;
		period_count = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		out_ready    = 1'b0;
		arst_n       = 1'b0;
		reset_shadow();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 7;
		recv_idle_pct = 55;
		test_all_slots_idle();
		test_directed_schedules();
		test_output_backpressure();
		test_random_schedules(7, 55);
		test_random_schedules(55, 7);
		test_random_schedules(0, 0);

		$display("Run covered %0d ticks over %0d setup writes across three idle mixes.",
			ticks_sent, setup_writes);
		$display("Forecast actions: %0d start, %0d stop, %0d log; %0d errors.",
			starts_seen, stops_seen, logs_seen, error_count);
		if (error_count == 0 && forecast_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d results outstanding.", forecast_q.size());
		$display("FAIL");
		$finish;
	end

endmodule
